@@ rtl/core/tvcm_pkg.sv @@
`timescale 1ns / 1ps
package tvcm_pkg;
  localparam int CoordW  = 16;
  localparam int EdgeW   = CoordW + 1;        // 17
  localparam int CrossW  = 2 * EdgeW + 1;     // 35
  localparam int ProdW   = CrossW + EdgeW;    // 52
  localparam int TripW   = ProdW + 2;         // 54
  localparam int MagW    = TripW - 1;         // 53
  localparam int VolW    = 48;
  localparam int PipeDepth = 5;
endpackage

@@ rtl/core/tvcm_div6.sv @@
`timescale 1ns / 1ps
// Exact floor(mag/6): shift out the factor two, then divide by 3 in two
// register stages. Split h into 26-bit halves; since 2^26 mod 3 is 1,
// floor(h/3) = floor(hi/3) * 2^26 + floor(((hi mod 3) * 2^26 + lo) / 3).
// Each division uses a reciprocal multiply, exact for the operands here, which stay below 2^28.
module tvcm_div6 (
  input  logic                    clk,
  input  logic                    en,
  input  logic [tvcm_pkg::MagW-1:0] mag,
  output logic [tvcm_pkg::VolW-1:0] quo
);
  import tvcm_pkg::*;
  localparam int HW = MagW - 1;  // 52 bits after halving
  localparam int SW = HW / 2;    // 26 bits per half
  localparam int PW = SW + 34;   // reciprocal product width
  localparam logic [31:0] Recip3 = 32'hAAAAAAAB;
  logic [HW-1:0] h;
  logic [PW-1:0] hi_prod;
  logic [SW-1:0] hi_q_next;
  logic [SW-1:0] hi_rem;
  logic [SW-1:0] hi_q;
  logic [1:0] hi_r;
  logic [SW-1:0] lo;
  logic [SW+1:0] x;
  logic [PW-1:0] x_prod;
  logic [HW-1:0] quo_next;
  assign h = mag[MagW-1:1];

  // high half: quotient and remainder by three
  assign hi_prod = PW'(h[HW-1:SW]) * PW'(Recip3);
  assign hi_q_next = hi_prod[33 +: SW];
  assign hi_rem = h[HW-1:SW] - hi_q_next - {hi_q_next[SW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      hi_q <= hi_q_next;
      hi_r <= hi_rem[1:0];
      lo <= h[SW-1:0];
    end
  end

  // low half with the carried remainder; its quotient stays below 2^26
  assign x = {hi_r, lo};
  assign x_prod = PW'(x) * PW'(Recip3);
  assign quo_next = {hi_q, x_prod[33 +: SW]};

  always_ff @(posedge clk) begin
    if (en) quo <= quo_next[VolW-1:0];
  end
endmodule

@@ rtl/core/tetrahedron_volume_cayley_menger.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake         Payload
// in       in   valid / stall     v0_x..v3_z, 16-bit signed Q8.8
// out      out  out_valid / out_stall  volume, 48-bit unsigned
// Five register stages: edges, cross products, triple product and magnitude,
// divide high half, divide low half.
// One request enters per cycle while stall is low.
// rst clears the stage valid bits only.
// A stall on the output while out_valid is high freezes every stage; stall on input follows it.
module tetrahedron_volume_cayley_menger (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  input  logic signed [15:0] v0_x, v0_y, v0_z,
  input  logic signed [15:0] v1_x, v1_y, v1_z,
  input  logic signed [15:0] v2_x, v2_y, v2_z,
  input  logic signed [15:0] v3_x, v3_y, v3_z,
  output logic out_valid,
  input  logic out_stall,
  output logic [47:0] volume
);
  import tvcm_pkg::*;
  logic [PipeDepth-1:0] vld;
  logic adv;
  assign adv = !(vld[PipeDepth-1] && out_stall);
  assign stall = !adv;
  assign out_valid = vld[PipeDepth-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[PipeDepth-2:0], valid};
  end

  // stage 1: edge vectors
  logic signed [EdgeW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= EdgeW'(v1_x) - EdgeW'(v0_x);
      ay <= EdgeW'(v1_y) - EdgeW'(v0_y);
      az <= EdgeW'(v1_z) - EdgeW'(v0_z);
      bx <= EdgeW'(v2_x) - EdgeW'(v0_x);
      by <= EdgeW'(v2_y) - EdgeW'(v0_y);
      bz <= EdgeW'(v2_z) - EdgeW'(v0_z);
      cx <= EdgeW'(v3_x) - EdgeW'(v0_x);
      cy <= EdgeW'(v3_y) - EdgeW'(v0_y);
      cz <= EdgeW'(v3_z) - EdgeW'(v0_z);
    end
  end

  // stage 2: cross product b x c
  logic signed [CrossW-1:0] k0, k1, k2;
  logic signed [EdgeW-1:0] ax2, ay2, az2;
  always_ff @(posedge clk) begin
    if (adv) begin
      k0 <= CrossW'(by) * CrossW'(cz) - CrossW'(bz) * CrossW'(cy);
      k1 <= CrossW'(bx) * CrossW'(cz) - CrossW'(bz) * CrossW'(cx);
      k2 <= CrossW'(bx) * CrossW'(cy) - CrossW'(by) * CrossW'(cx);
      ax2 <= ax; ay2 <= ay; az2 <= az;
    end
  end

  // stage 3: triple product and magnitude
  logic signed [TripW-1:0] t;
  logic [MagW-1:0] mag;
  always_comb begin
    t = TripW'(ax2) * TripW'(k0) - TripW'(ay2) * TripW'(k1) + TripW'(az2) * TripW'(k2);
  end
  always_ff @(posedge clk) begin
    if (adv) mag <= t[TripW-1] ? MagW'(-t) : MagW'(t);
  end

  // stages 4 and 5: divide by six
  tvcm_div6 u_div6 (.clk(clk), .en(adv), .mag(mag), .quo(volume));
endmodule
